// ----- rtl/i2ctpr_pkg.sv -----
// Shared types and constants of the paged I2C target register map.
`default_nettype none
package i2ctpr_pkg;

    localparam int PAGE_BYTES = 128;
    localparam int OFF_W      = 7;
    localparam int ADDR_W     = 8;

    localparam logic [OFF_W-1:0] OFF_LAST   = 7'h7f;
    localparam logic [OFF_W-1:0] SELECT_OFF = 7'h7f;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef struct packed {
        logic clear_step;
        logic wr;
        logic rd;
        logic stop;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/i2ctpr_dp.sv -----
// Datapath: page memory, address pointer, page select shadow and output register.
`default_nettype none
module i2ctpr_dp
    import i2ctpr_pkg::*;
#(
    parameter int UPPER_PAGES = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    input  wire logic [7:0] data_in,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_data,
    output logic            out_ok
);

    localparam int DEPTH = PAGE_BYTES * (1 + UPPER_PAGES);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PG_W  = IDX_W - OFF_W;

    logic [7:0]       mem [DEPTH];
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic             expect_reg, expect_next;
    logic [1:0]       tp_reg, tp_next;
    logic [7:0]       select_reg, select_next;
    logic [7:0]       rdata_reg;
    logic             rok_reg, rok_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_ok_reg, out_ok_next;

    logic             half;
    logic [OFF_W-1:0] off;
    logic [PG_W-1:0]  page_num;
    logic [IDX_W-1:0] idx;
    logic             sel_ok;
    logic             access_ok;
    logic [ADDR_W-1:0] addr_adv;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [7:0]       mem_wd;

    assign half      = addr_reg[ADDR_W-1];
    assign off       = addr_reg[OFF_W-1:0];
    assign page_num  = half ? (PG_W'(tp_reg) + PG_W'(1)) : '0;
    assign idx       = {page_num, off};
    assign sel_ok    = select_reg < 8'(UPPER_PAGES);
    assign access_ok = !half || sel_ok;
    assign addr_adv  = (off == OFF_LAST) ? {half, {OFF_W{1'b0}}} : addr_reg + 8'd1;

    assign mem_we = cmd.clear_step || (cmd.wr && !expect_reg && access_ok);
    assign mem_wa = cmd.clear_step ? clr_cnt_reg : idx;
    assign mem_wd = cmd.clear_step ? 8'd0 : data_in;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[idx];
        end
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        expect_next    = expect_reg;
        tp_next        = tp_reg;
        select_next    = select_reg;
        rok_next       = rok_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + IDX_W'(1);
        end
        if (cmd.wr)
        begin
            if (expect_reg)
            begin
                addr_next   = data_in;
                expect_next = 1'b0;
                if (data_in[ADDR_W-1])
                begin
                    tp_next = sel_ok ? select_reg[1:0] : 2'd0;
                end
            end
            else
            begin
                if (access_ok && !half && off == SELECT_OFF)
                begin
                    select_next = data_in;
                end
                addr_next = addr_adv;
            end
        end
        if (cmd.rd)
        begin
            rok_next  = access_ok;
            addr_next = addr_adv;
        end
        if (cmd.stop)
        begin
            expect_next = 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rok_reg ? rdata_reg : 8'd0;
            out_ok_next    = rok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            addr_reg      <= '0;
            expect_reg    <= 1'b1;
            tp_reg        <= 2'd0;
            select_reg    <= 8'd0;
            rok_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            addr_reg      <= addr_next;
            expect_reg    <= expect_next;
            tp_reg        <= tp_next;
            select_reg    <= select_next;
            rok_reg       <= rok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign stat.clear_last = (clr_cnt_reg == IDX_W'(DEPTH - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_ok          = out_ok_reg;

endmodule
`default_nettype wire

// ----- rtl/i2ctpr_ctrl.sv -----
// Controller: memory clearing sweep, word intake and read sequencing.
`default_nettype none
module i2ctpr_ctrl
    import i2ctpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_op,
    output logic            in_ready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept = in_valid && ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_WRITE: cmd.wr = 1'b1;
                        OP_READ:
                        begin
                            cmd.rd     = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_STOP:  cmd.stop = 1'b1;
                        default:  ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule
`default_nettype wire

// ----- rtl/i2c_target_paged_register_map.sv -----
// Top level of the paged I2C target register map.
// Input stream: one word per I2C byte event; tuser carries the operation
// (write byte, read request, stop), tdata the written byte.
// Output stream: one word per read request; tdata is the byte, tuser flags
// whether the addressed page exists (byte is 0 when it does not).
// Lower page at 0x00..0x7F, UPPER_PAGES upper pages at 0x80..0xFF; lower
// byte 0x7F selects the upper page when the address byte arrives.
// After reset the whole page memory is cleared one byte per cycle;
// tready stays low meanwhile.
// Writes and stops are applied as they are accepted. A read goes through
// the synchronous memory read, then the load into the output register;
// the load waits while the output register still holds an untaken word.
// When the receiver stalls, the output register holds its word; further
// writes and stops are still taken, and a second read is accepted but then
// blocks the input until the held word is taken.
`default_nettype none
module i2c_target_paged_register_map
    import i2ctpr_pkg::*;
#(
    parameter int UPPER_PAGES = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_in
    input  wire logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] read_data
    output logic [0:0]      m_axis_tuser    // [0] data_valid
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     out_ok;

    i2ctpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2ctpr_dp #(
        .UPPER_PAGES (UPPER_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .data_in   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_ok    (out_ok)
    );

    assign m_axis_tuser[0] = out_ok;

endmodule
`default_nettype wire

// ----- verif/i2c_target_paged_register_map_test.sv -----
// Self-checking testbench for the paged I2C target register map.
`default_nettype none
module i2c_target_paged_register_map_test;
    import i2ctpr_pkg::*;

    localparam int UPPER_PAGES  = 2;
    localparam int STORE_BYTES  = PAGE_BYTES * (1 + UPPER_PAGES);
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT     = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } byte_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } read_reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    wire logic  s_axis_tready;
    logic [7:0] s_axis_tdata = '0;      // [7:0] data_in
    logic [1:0] s_axis_tuser = '0;      // [1:0] operation
    wire logic  m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    wire logic [7:0] m_axis_tdata;      // [7:0] read_data
    wire logic [0:0] m_axis_tuser;      // [0] data_valid

    // mirror of the target's register map
    logic [7:0] mem_image [STORE_BYTES];
    logic       await_addr = 1'b1;
    logic [7:0] addr_ptr = '0;
    logic [1:0] latched_page = '0;

    byte_event_t byte_events [$];
    read_reply_t expected_reads [$];
    logic        word_pending;
    int          sent_count = 0;
    int          accepted_count = 0;
    int          counted_items = 0;
    int          mismatch_count = 0;
    logic        steady;

    i2c_target_paged_register_map #(.UPPER_PAGES(UPPER_PAGES)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        foreach (mem_image[i]) mem_image[i] = '0;
    end

    // long stretch with both sides always ready
    assign steady = (accepted_count >= 700) && (accepted_count < 1000);

    assign word_pending = (sent_count != accepted_count);

    function automatic void push_event(logic [1:0] op, logic [7:0] data);
        byte_events.push_back('{op: op, data: data});
        if (op != OP_UNUSED)
            counted_items++;
    endfunction

    function automatic void predict_event(logic [1:0] op, logic [7:0] data);
        logic sel_ok;
        logic access_ok;
        int   idx;
        sel_ok = mem_image[SELECT_OFF] < UPPER_PAGES;
        access_ok = !addr_ptr[7] || sel_ok;
        idx = addr_ptr[7] ? PAGE_BYTES * (1 + latched_page) + addr_ptr[6:0]
                          : int'(addr_ptr[6:0]);
        case (op)
            OP_WRITE:
                if (await_addr)
                begin
                    addr_ptr = data;
                    await_addr = 1'b0;
                    if (data[7])
                        latched_page = sel_ok ? mem_image[SELECT_OFF][1:0] : 2'd0;
                end
                else
                begin
                    if (access_ok)
                        mem_image[idx] = data;
                    addr_ptr = (addr_ptr[6:0] == OFF_LAST) ? {addr_ptr[7], 7'h00}
                                                           : addr_ptr + 8'd1;
                end
            OP_READ:
            begin
                expected_reads.push_back('{data: access_ok ? mem_image[idx] : 8'h00,
                                           valid: access_ok});
                addr_ptr = (addr_ptr[6:0] == OFF_LAST) ? {addr_ptr[7], 7'h00}
                                                       : addr_ptr + 8'd1;
            end
            OP_STOP:
                await_addr = 1'b1;
            default:
                ;
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        byte_event_t ev;
        if (rst_n && !word_pending)
        begin
            if (byte_events.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                ev = byte_events.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= ev.data;
                s_axis_tuser  <= ev.op;
                sent_count++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_event(s_axis_tuser, s_axis_tdata);
            accepted_count++;
        end
    end

    // monitor
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        read_reply_t exp_word;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_reads.size() == 0)
            begin
                $display("%0t unexpected word: got data %02h valid %0d",
                         $time, m_axis_tdata, m_axis_tuser[0]);
                mismatch_count++;
            end
            else
            begin
                exp_word = expected_reads.pop_front();
                if (m_axis_tdata !== exp_word.data || m_axis_tuser[0] !== exp_word.valid)
                begin
                    $display("%0t read mismatch: expected data %02h valid %0d, got data %02h valid %0d",
                             $time, exp_word.data, exp_word.valid,
                             m_axis_tdata, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int kind;
        int n;
        logic [7:0] addr;

        // directed: read before any address, unused opcode
        push_event(OP_READ, 8'hff);
        push_event(OP_UNUSED, 8'h5a);
        // lower writes across the wrap, select set to page 1
        push_event(OP_WRITE, 8'h7e);
        push_event(OP_WRITE, 8'haa);
        push_event(OP_WRITE, 8'h01);
        push_event(OP_WRITE, 8'h00);
        push_event(OP_STOP, 8'h00);
        // upper access wrapping 0xFF to 0x80 on page 1
        push_event(OP_WRITE, 8'hff);
        push_event(OP_WRITE, 8'hc3);
        push_event(OP_WRITE, 8'hff);
        push_event(OP_STOP, 8'hff);
        // invalid select at address time and at access time
        push_event(OP_WRITE, 8'h7f);
        push_event(OP_WRITE, 8'hff);
        push_event(OP_STOP, 8'h00);
        push_event(OP_WRITE, 8'hfe);
        push_event(OP_READ, 8'h00);
        push_event(OP_WRITE, 8'h11);
        push_event(OP_READ, 8'h00);
        // select set back to page 0, then upper reads and lower reads across the wrap
        push_event(OP_STOP, 8'h00);
        push_event(OP_WRITE, 8'h7f);
        push_event(OP_WRITE, 8'h00);
        push_event(OP_STOP, 8'h00);
        push_event(OP_WRITE, 8'hff);
        push_event(OP_READ, 8'h00);
        push_event(OP_READ, 8'h00);
        push_event(OP_STOP, 8'h00);
        push_event(OP_WRITE, 8'h7e);
        push_event(OP_READ, 8'h00);
        push_event(OP_READ, 8'h00);
        push_event(OP_READ, 8'h00);
        push_event(OP_STOP, 8'h00);
        push_event(OP_READ, 8'h00);

        while (counted_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 12)
            begin
                push_event(OP_STOP, 8'($urandom));
                push_event(OP_WRITE, 8'h7f);
                push_event(OP_WRITE, ($urandom_range(3) != 0) ? 8'($urandom_range(1))
                                                             : 8'($urandom));
            end
            else if (kind < 82)
            begin
                push_event(OP_STOP, 8'($urandom));
                addr[7] = 1'($urandom_range(1));
                addr[6:0] = $urandom_range(1) ? 7'($urandom_range(127 - 8, 127))
                                              : 7'($urandom);
                push_event(OP_WRITE, addr);
                n = $urandom_range(1, 12);
                repeat (n)
                    push_event($urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    push_event(2'($urandom_range(3)), 8'($urandom));
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_events.size() > 0 || word_pending)
            @(posedge clk);
        while (expected_reads.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
